### design/xxf_pkg.sv
package xxf_pkg;

  // Sizes and defaults.
  localparam int unsigned DefaultDepth = 8;
  localparam int unsigned ByteW        = 8;
  localparam int unsigned LimitW       = 4;
  localparam int unsigned LevelW       = 4;
  localparam int unsigned CfgIdxW      = 4;
  localparam int unsigned CfgDataW     = 8;

  localparam logic [LimitW-1:0] UpperLimitReset = 4'd5;
  localparam logic [LimitW-1:0] LowerLimitReset = 4'd2;

  // Character codes.
  localparam logic [ByteW-1:0] CharXon       = 8'h11;
  localparam logic [ByteW-1:0] CharXoff      = 8'h13;
  localparam logic [ByteW-1:0] CharCr        = 8'd13;
  localparam logic [ByteW-1:0] CharLf        = 8'd10;
  localparam logic [ByteW-1:0] CharEof       = 8'd26;
  localparam logic [ByteW-1:0] PrintableMin  = 8'd32;

  // Operation codes.
  localparam logic OpPush = 1'b0;
  localparam logic OpPop  = 1'b1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgUpperLimit = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgLowerLimit = 4'd1;

  typedef struct packed {
    logic             operation;
    logic [ByteW-1:0] rx_byte;
  } xxf_in_t;

  typedef struct packed {
    logic              read_valid;
    logic [ByteW-1:0]  read_byte;
    logic              read_consumable;
    logic              overflow;
    logic              send_flow;
    logic [ByteW-1:0]  flow_char;
    logic [LevelW-1:0] fill_level;
    logic              paused;
  } xxf_out_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } xxf_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic push_go;
    logic pop_issue;
    logic pop_finish;
  } xxf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;
  } xxf_status_t;

  function automatic logic is_consumable(input logic [ByteW-1:0] b);
    return (b >= PrintableMin) || (b == CharCr) || (b == CharLf) || (b == CharEof);
  endfunction

endpackage

### design/xxf_ctrl.sv
module xxf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                is_pop_i,
  input  xxf_pkg::xxf_status_t status_i,
  output logic                in_stall_o,
  output xxf_pkg::xxf_cmd_t   cmd_o
);
  import xxf_pkg::*;

  xxf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = status_i.out_busy;
        if (in_valid_i && !status_i.out_busy) begin
          if (is_pop_i == OpPop) begin
            // The store read is registered, so a pop finishes in ST_READ once the output is free.
            cmd_o.pop_issue = 1'b1;
            state_d         = ST_READ;
          end else begin
            cmd_o.push_go = 1'b1;
          end
        end
      end
      ST_READ: begin
        if (!status_i.out_busy) begin
          cmd_o.pop_finish = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### design/xxf_datapath.sv
module xxf_datapath #(
  parameter int unsigned DEPTH = xxf_pkg::DefaultDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  xxf_pkg::xxf_in_t              in_data_i,
  input  xxf_pkg::xxf_cmd_t             cmd_i,
  output xxf_pkg::xxf_status_t          status_o,
  input  logic                          cfg_we_i,
  input  logic [xxf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [xxf_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output xxf_pkg::xxf_out_t             out_data_o
);
  import xxf_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = (CntW > LimitW) ? CntW : LimitW;

  logic [ByteW-1:0]  mem_q [DEPTH];
  logic [ByteW-1:0]  rd_data_q;
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              running_q, running_d;
  logic [LimitW-1:0] upper_q, lower_q;
  logic              out_valid_q;
  xxf_out_t          out_q, res;

  logic              full, nonempty, xoff, xon, cons, load;
  logic [CmpW-1:0]   lvl_ext;

  assign full     = (cnt_q == CntW'(DEPTH));
  assign nonempty = (cnt_q != '0);
  assign cons     = is_consumable(rd_data_q);
  assign load     = cmd_i.push_go | cmd_i.pop_finish;

  always_comb begin
    wr_ptr_d  = wr_ptr_q;
    rd_ptr_d  = rd_ptr_q;
    cnt_d     = cnt_q;
    running_d = running_q;
    xoff      = 1'b0;
    xon       = 1'b0;
    res       = '0;
    if (cmd_i.push_go) begin
      if (!full) begin
        wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
        cnt_d    = cnt_q + CntW'(1);
      end
      // The XOFF test is made even when the byte was dropped.
      xoff         = (CmpW'(cnt_d) >= CmpW'(upper_q)) && running_q;
      res.overflow = full;
    end else if (cmd_i.pop_finish && nonempty) begin
      rd_ptr_d            = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      cnt_d               = cnt_q - CntW'(1);
      xon                 = cons && (CmpW'(cnt_d) <= CmpW'(lower_q)) && !running_q;
      res.read_valid      = 1'b1;
      res.read_byte       = rd_data_q;
      res.read_consumable = cons;
    end
    if (xoff) begin
      running_d = 1'b0;
    end else if (xon) begin
      running_d = 1'b1;
    end
    res.send_flow = xoff | xon;
    res.flow_char = xoff ? CharXoff : (xon ? CharXon : '0);
    lvl_ext       = CmpW'(cnt_d);
    res.fill_level = (lvl_ext > CmpW'(15)) ? LevelW'(15) : lvl_ext[LevelW-1:0];
    res.paused    = !running_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_go && !full) begin
      mem_q[wr_ptr_q] <= in_data_i.rx_byte;
    end
    if (cmd_i.pop_issue) begin
      rd_data_q <= mem_q[rd_ptr_q];
    end
    if (load) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      cnt_q       <= '0;
      running_q   <= 1'b1;
      upper_q     <= UpperLimitReset;
      lower_q     <= LowerLimitReset;
      out_valid_q <= 1'b0;
    end else begin
      wr_ptr_q  <= wr_ptr_d;
      rd_ptr_q  <= rd_ptr_d;
      cnt_q     <= cnt_d;
      running_q <= running_d;
      if (cfg_we_i) begin
        if (cfg_index_i == CfgUpperLimit) begin
          upper_q <= cfg_data_i[LimitW-1:0];
        end else if (cfg_index_i == CfgLowerLimit) begin
          lower_q <= cfg_data_i[LimitW-1:0];
        end
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.out_busy = out_valid_q && out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

endmodule

### design/xon_xoff_receive_fifo.sv
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i / in_stall_o | xxf_in_t (operation, rx_byte)
// out     | output    | out_valid_o / out_stall_i | xxf_out_t (one result per item)
// cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// A push's result is in the output register after the accepting edge.
// A pop goes through the registered read port of the byte store and the ST_READ state.
// Reset clears pointers, count and the output valid flag; the sender starts running.
// While a result waits under stall, the block holds off the next transaction.
module xon_xoff_receive_fifo #(
  parameter int unsigned DEPTH = xxf_pkg::DefaultDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  xxf_pkg::xxf_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output xxf_pkg::xxf_out_t             out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [xxf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [xxf_pkg::CfgDataW-1:0]  cfg_data_i
);
  import xxf_pkg::*;

  xxf_cmd_t    cmd;
  xxf_status_t status;

  assign cfg_ready_o = 1'b1;

  xxf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .is_pop_i   (in_data_i.operation),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  xxf_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef ASSERT_OFF
  a_pop_blocks_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.operation == OpPop) |=> in_stall_o)
    else $error("input accepted while a pop was still reading the store");

  a_read_not_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.read_valid |-> !out_data_o.overflow)
    else $error("result reports both a read and an overflow");

  a_empty_read_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.read_valid |->
      (out_data_o.read_byte == '0) && !out_data_o.read_consumable)
    else $error("result without a read carries read data");

  a_xoff_pauses: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.send_flow && (out_data_o.flow_char == CharXoff) |->
      out_data_o.paused)
    else $error("XOFF sent but sender not marked paused");
`endif

endmodule

### verif/xon_xoff_receive_fifo_tb.sv
`timescale 1ns / 100ps

module xon_xoff_receive_fifo_tb;
  import xxf_pkg::*;

  localparam int unsigned DEPTH      = DefaultDepth;
  localparam int unsigned CycleLimit = 200000;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  xxf_in_t             in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  xxf_out_t            out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  xon_xoff_receive_fifo #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Shadow copy of the receive buffer and the flow control state.
  logic [ByteW-1:0]  shadow_bytes [DEPTH];
  int unsigned       shadow_rd_ptr   = 0;
  int unsigned       shadow_wr_ptr   = 0;
  int unsigned       shadow_count    = 0;
  bit                shadow_running  = 1'b1;
  logic [LimitW-1:0] shadow_upper    = UpperLimitReset;
  logic [LimitW-1:0] shadow_lower    = LowerLimitReset;

  xxf_in_t     pending_items [$];
  xxf_out_t    expected_results [$];
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  bit          steady      = 1'b0;

  function automatic xxf_out_t fifo_step_result(input xxf_in_t item);
    xxf_out_t   res;
    logic [7:0] b;
    res = '0;
    if (item.operation == OpPush) begin
      if (shadow_count >= DEPTH) begin
        res.overflow = 1'b1;
      end else begin
        shadow_bytes[shadow_wr_ptr] = item.rx_byte;
        shadow_wr_ptr = (shadow_wr_ptr + 1) % DEPTH;
        shadow_count++;
      end
      // The XOFF test runs even when the byte was dropped.
      if (shadow_count >= shadow_upper && shadow_running) begin
        shadow_running = 1'b0;
        res.send_flow  = 1'b1;
        res.flow_char  = CharXoff;
      end
    end else if (shadow_count != 0) begin
      b = shadow_bytes[shadow_rd_ptr];
      shadow_rd_ptr = (shadow_rd_ptr + 1) % DEPTH;
      shadow_count--;
      res.read_valid = 1'b1;
      res.read_byte  = b;
      if (b >= PrintableMin || b == CharCr || b == CharLf || b == CharEof) begin
        res.read_consumable = 1'b1;
        if (shadow_count <= shadow_lower && !shadow_running) begin
          shadow_running = 1'b1;
          res.send_flow  = 1'b1;
          res.flow_char  = CharXon;
        end
      end
    end
    res.fill_level = (shadow_count > 15) ? 4'd15 : shadow_count[LevelW-1:0];
    res.paused     = !shadow_running;
    return res;
  endfunction

  function automatic bit take_break();
    return !steady && ($urandom_range(99) < 34);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) begin
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Driver: a held item stays on the bus until the block accepts it.
  always @(posedge clk_i) begin : drive_items
    xxf_in_t next_item;
    logic    next_valid;
    next_item  = in_data_i;
    next_valid = in_valid_i;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(fifo_step_result(in_data_i));
        next_valid = 1'b0;
      end
      if (!next_valid && pending_items.size() != 0 && !take_break()) begin
        next_item  = pending_items.pop_front();
        next_valid = 1'b1;
      end
    end
    in_valid_i <= next_valid;
    in_data_i  <= next_item;
  end

  always @(posedge clk_i) begin : check_results
    xxf_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = expected_results.pop_front();
        if (out_data_o.read_valid !== want.read_valid)
          report_mismatch($sformatf("read_valid %b, want %b",
                                    out_data_o.read_valid, want.read_valid));
        if (out_data_o.read_byte !== want.read_byte)
          report_mismatch($sformatf("read_byte %h, want %h",
                                    out_data_o.read_byte, want.read_byte));
        if (out_data_o.read_consumable !== want.read_consumable)
          report_mismatch($sformatf("read_consumable %b, want %b",
                                    out_data_o.read_consumable, want.read_consumable));
        if (out_data_o.overflow !== want.overflow)
          report_mismatch($sformatf("overflow %b, want %b",
                                    out_data_o.overflow, want.overflow));
        if (out_data_o.send_flow !== want.send_flow)
          report_mismatch($sformatf("send_flow %b, want %b",
                                    out_data_o.send_flow, want.send_flow));
        if (out_data_o.flow_char !== want.flow_char)
          report_mismatch($sformatf("flow_char %h, want %h",
                                    out_data_o.flow_char, want.flow_char));
        if (out_data_o.fill_level !== want.fill_level)
          report_mismatch($sformatf("fill_level %0d, want %0d",
                                    out_data_o.fill_level, want.fill_level));
        if (out_data_o.paused !== want.paused)
          report_mismatch($sformatf("paused %b, want %b",
                                    out_data_o.paused, want.paused));
      end
    end
    out_stall_i <= take_break();
  end

  task automatic queue_item(input logic op, input logic [ByteW-1:0] b);
    xxf_in_t item;
    item.operation = op;
    item.rx_byte   = b;
    pending_items.push_back(item);
  endtask

  // Control characters and values just around them are weighted up.
  function automatic logic [ByteW-1:0] random_byte();
    case ($urandom_range(5))
      0: return ByteW'(CharCr + $urandom_range(2) - 1);
      1: return ByteW'(CharLf + $urandom_range(2) - 1);
      2: return ByteW'(CharEof + $urandom_range(2) - 1);
      3: return ByteW'($urandom_range(PrintableMin - 1));
      default: return ByteW'($urandom);
    endcase
  endfunction

  // Bursts with a varying push share sweep the fill level between empty and full.
  task automatic add_random_items(input int unsigned n);
    int unsigned burst;
    int unsigned push_pct;
    int unsigned left;
    left = n;
    while (left != 0) begin
      burst = $urandom_range(32, 8);
      case ($urandom_range(2))
        0: push_pct = 15;
        1: push_pct = 50;
        default: push_pct = 85;
      endcase
      repeat (burst) begin
        if (left != 0) begin
          if ($urandom_range(99) < push_pct) queue_item(OpPush, random_byte());
          else queue_item(OpPop, ByteW'($urandom));
          left--;
        end
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(negedge clk_i);
    // A pop goes through the ST_READ state; give the block a little slack before the next write.
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx,
                                input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CfgUpperLimit) shadow_upper = val[LimitW-1:0];
    else if (idx == CfgLowerLimit) shadow_lower = val[LimitW-1:0];
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [CfgDataW-1:0] upper,
                           input logic [CfgDataW-1:0] lower,
                           input int unsigned n);
    write_register(CfgUpperLimit, upper);
    write_register(CfgLowerLimit, lower);
    @(negedge clk_i);
    add_random_items(n);
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    queue_item(OpPop, 8'hFF);
    queue_item(OpPush, 8'h00);
    queue_item(OpPush, 8'hFF);
    queue_item(OpPush, CharCr);
    queue_item(OpPush, CharLf);
    queue_item(OpPush, CharEof);
    queue_item(OpPush, ByteW'(PrintableMin - 1));
    queue_item(OpPush, PrintableMin);
    queue_item(OpPush, 8'h7F);
    queue_item(OpPush, 8'h55);
    repeat (DEPTH + 1) queue_item(OpPop, 8'h00);
    add_random_items(60);
    wait_drained();

    run_phase(CfgDataW'(DEPTH), 8'h00, 150);
    run_phase(8'h01, CfgDataW'(DEPTH), 150);
    write_register(CfgIdxW'($urandom_range(15, 2)), CfgDataW'($urandom));
    run_phase(8'h00, 8'h00, 120);
    run_phase(8'hFF, 8'hFF, 120);
    steady = 1'b1;
    run_phase(8'h63, 8'h91, 200);
    steady = 1'b0;
    run_phase(8'h02, 8'h07, 150);
    repeat (3) run_phase(CfgDataW'($urandom), CfgDataW'($urandom), 100);

    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
design/xxf_pkg.sv
design/xxf_ctrl.sv
design/xxf_datapath.sv
design/xon_xoff_receive_fifo.sv
verif/xon_xoff_receive_fifo_tb.sv
